>>> design/dkcs_pkg.sv
package dkcs_pkg;

   localparam int unsigned KEY_COUNT = 8;
   localparam int unsigned KIDX_W    = 3;
   localparam int unsigned CODE_W    = 8;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned CSR_W     = 64;

   localparam logic [KIDX_W-1:0] LAST_KEY = KIDX_W'(KEY_COUNT - 1);

   localparam logic [CODE_W-1:0] BREAK_PREFIX = 8'hF0;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_DEBOUNCE_MS   = 2'd0;
   localparam logic [1:0] CSR_MAKE_CODES    = 2'd1;
   localparam logic [1:0] CSR_RELEASE_CODES = 2'd2;
   localparam logic [1:0] CSR_RELEASE_STYLE = 2'd3;

   localparam logic [7:0]       DEBOUNCE_RST      = 8'd10;
   localparam logic [CSR_W-1:0] MAKE_CODES_RST    = 64'h0000_0000_007D_7524;
   localparam logic [CSR_W-1:0] RELEASE_CODES_RST = 64'h0000_0000_00C9_C892;
   localparam logic             RELEASE_STYLE_RST = 1'b1;

   typedef enum logic [0:0] {
      OP_SAMPLE = 1'b0,
      OP_SEND   = 1'b1
   } op_type;

   typedef struct packed {
      logic              op;
      logic [7:0]        key_levels;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [KIDX_W-1:0] key_index;
      logic              pressed;
      logic              last;
   } rsp_type;

   // One report handed from the front end to the back end.
   typedef struct packed {
      logic [KIDX_W-1:0] key_index;
      logic              pressed;
   } cmd_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_SCAN,
      FR_SEND
   } front_state_type;

   typedef enum logic [0:0] {
      BK_FIRST,
      BK_SECOND
   } back_state_type;

endpackage

>>> design/debounced_key_code_scheduler_core.sv
// Debounced key scanner and scan-code reporter for up to eight keys. A key sample word
// (op 0) is compared with the accepted key state one key per cycle, so it holds req_ready
// low after acceptance until all keys are scanned; a change is taken only when at least
// debounce_ms have passed since the key's last accepted change (wrap-around time), and the
// key is then marked pending. A send slot word (op 1) picks the next pending key round-robin
// in the cycle after acceptance and queues a report in a two-entry queue; it waits there
// only while that queue is full. The back end turns each report into one word (make code,
// or single release code) or two words (0xF0, then the make code), one word per cycle while
// rsp_ready holds, from a registered output. Reset clears all key timestamps at once, with
// no clearing pass. Configuration writes take effect at once and must only be made while
// the block is idle.
module debounced_key_code_scheduler_core import dkcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   logic [7:0]       debounce_ff, debounce_in;
   logic [CSR_W-1:0] make_ff, make_in;
   logic [CSR_W-1:0] release_ff, release_in;
   logic             style_ff, style_in;

   logic             fr_cmd_valid;
   logic             fr_cmd_ready;
   cmd_type          fr_cmd_data;
   logic             bk_cmd_valid;
   logic             bk_cmd_ready;
   cmd_type          bk_cmd_data;

   always_comb begin
      debounce_in = debounce_ff;
      make_in     = make_ff;
      release_in  = release_ff;
      style_in    = style_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS:   debounce_in = csr_wdata[7:0];
            CSR_MAKE_CODES:    make_in     = csr_wdata;
            CSR_RELEASE_CODES: release_in  = csr_wdata;
            CSR_RELEASE_STYLE: style_in    = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RST;
         make_ff     <= MAKE_CODES_RST;
         release_ff  <= RELEASE_CODES_RST;
         style_ff    <= RELEASE_STYLE_RST;
      end else begin
         debounce_ff <= debounce_in;
         make_ff     <= make_in;
         release_ff  <= release_in;
         style_ff    <= style_in;
      end
   end

   dkcs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .debounce_ms (debounce_ff),
      .cmd_valid   (fr_cmd_valid),
      .cmd_ready   (fr_cmd_ready),
      .cmd_data    (fr_cmd_data)
   );

   dkcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_cmd_valid),
      .push_ready (fr_cmd_ready),
      .push_data  (fr_cmd_data),
      .pop_valid  (bk_cmd_valid),
      .pop_ready  (bk_cmd_ready),
      .pop_data   (bk_cmd_data)
   );

   dkcs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (bk_cmd_valid),
      .cmd_ready     (bk_cmd_ready),
      .cmd_data      (bk_cmd_data),
      .make_codes    (make_ff),
      .release_codes (release_ff),
      .release_style (style_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

   // A key sample keeps the front end busy while it scans the keys.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.op == OP_SAMPLE) |=> !req_ready)
      else $error("front end took a new word during a key scan");

   // Only the break prefix of a release can be a word that is not the last of its report.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (!rsp_data.pressed && rsp_data.code == BREAK_PREFIX))
      else $error("non-final report word is not a break prefix");

   // The make code of a two-word release follows its prefix at once, for the same key.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last) |=>
      (rsp_valid && rsp_data.last && !rsp_data.pressed &&
       rsp_data.key_index == $past(rsp_data.key_index)))
      else $error("second word of a release report is missing or wrong");

endmodule

>>> design/dkcs_front.sv
module dkcs_front import dkcs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   input  logic [7:0] debounce_ms,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd_data
);

   front_state_type       state_ff, state_in;
   logic [TIME_W-1:0]     times_ff [KEY_COUNT];
   logic [TIME_W-1:0]     times_in [KEY_COUNT];
   logic [KEY_COUNT-1:0]  keys_ff, keys_in;
   logic [KEY_COUNT-1:0]  pending_ff, pending_in;
   logic [KIDX_W-1:0]     last_ff, last_in;
   logic [KEY_COUNT-1:0]  levels_ff, levels_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [KIDX_W-1:0]     idx_ff, idx_in;

   logic [TIME_W-1:0]     elapsed;
   logic                  settled;
   logic [KIDX_W-1:0]     start;
   logic [KIDX_W-1:0]     cand;
   logic [KIDX_W-1:0]     pick;
   logic                  found;

   assign elapsed = now_ff - times_ff[idx_ff];
   assign settled = elapsed >= {{(TIME_W-8){1'b0}}, debounce_ms};
   assign start   = (last_ff == LAST_KEY) ? '0 : last_ff + 1'b1;

   // Round-robin pick: first pending key at or after the key following the last one served.
   always_comb begin
      cand  = start;
      pick  = start;
      found = 1'b0;
      for (int n = 0; n < KEY_COUNT; n++) begin
         if (!found && pending_ff[cand]) begin
            pick  = cand;
            found = 1'b1;
         end
         cand = (cand == LAST_KEY) ? '0 : cand + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.op == OP_SEND) ? FR_SEND : FR_SCAN;
            end
         end
         FR_SCAN: begin
            if (idx_ff == LAST_KEY) begin
               state_in = FR_IDLE;
            end
         end
         FR_SEND: begin
            if (pending_ff == '0 || cmd_ready) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      times_in   = times_ff;
      keys_in    = keys_ff;
      pending_in = pending_ff;
      last_in    = last_ff;
      levels_in  = levels_ff;
      now_in     = now_ff;
      idx_in     = idx_ff;
      req_ready  = 1'b0;
      cmd_valid  = 1'b0;
      cmd_data.key_index = pick;
      cmd_data.pressed   = keys_ff[pick];
      unique case (state_ff)
         FR_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               levels_in = req_data.key_levels[KEY_COUNT-1:0];
               now_in    = req_data.now_ms;
               idx_in    = '0;
            end
         end
         FR_SCAN: begin
            // One key per cycle: a changed level counts only once the key has settled.
            if ((levels_ff[idx_ff] != keys_ff[idx_ff]) && settled) begin
               times_in[idx_ff]   = now_ff;
               pending_in[idx_ff] = 1'b1;
               keys_in[idx_ff]    = levels_ff[idx_ff];
            end
            idx_in = idx_ff + 1'b1;
         end
         FR_SEND: begin
            cmd_valid = found;
            if (found && cmd_ready) begin
               last_in          = pick;
               pending_in[pick] = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FR_IDLE;
         keys_ff    <= '0;
         pending_ff <= '0;
         last_ff    <= LAST_KEY;
         for (int k = 0; k < KEY_COUNT; k++) begin
            times_ff[k] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         keys_ff    <= keys_in;
         pending_ff <= pending_in;
         last_ff    <= last_in;
         times_ff   <= times_in;
      end
   end

   always_ff @(posedge clock) begin
      levels_ff <= levels_in;
      now_ff    <= now_in;
      idx_ff    <= idx_in;
   end

endmodule

>>> design/dkcs_queue.sv
module dkcs_queue import dkcs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type    entries_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_data   = entries_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> design/dkcs_back.sv
module dkcs_back import dkcs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  cmd_type          cmd_data,
   input  logic [CSR_W-1:0] make_codes,
   input  logic [CSR_W-1:0] release_codes,
   input  logic             release_style,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   back_state_type    state_ff, state_in;
   logic              valid_ff, valid_in;
   rsp_type           word_ff, word_in;
   logic [KIDX_W-1:0] key_ff, key_in;
   logic              out_free;
   logic [CODE_W-1:0] make_first;
   logic [CODE_W-1:0] release_first;
   logic [CODE_W-1:0] make_second;

   assign out_free      = !valid_ff || rsp_ready;
   assign make_first    = make_codes[{cmd_data.key_index, 3'b000} +: CODE_W];
   assign release_first = release_codes[{cmd_data.key_index, 3'b000} +: CODE_W];
   assign make_second   = make_codes[{key_ff, 3'b000} +: CODE_W];
   assign rsp_valid     = valid_ff;
   assign rsp_data      = word_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_FIRST: begin
            if (out_free && cmd_valid && !cmd_data.pressed && !release_style) begin
               state_in = BK_SECOND;
            end
         end
         BK_SECOND: begin
            if (out_free) begin
               state_in = BK_FIRST;
            end
         end
         default: state_in = BK_FIRST;
      endcase
   end

   always_comb begin
      cmd_ready = 1'b0;
      valid_in  = valid_ff && !rsp_ready;
      word_in   = word_ff;
      key_in    = key_ff;
      unique case (state_ff)
         BK_FIRST: begin
            cmd_ready = out_free;
            if (out_free && cmd_valid) begin
               valid_in          = 1'b1;
               key_in            = cmd_data.key_index;
               word_in.key_index = cmd_data.key_index;
               word_in.pressed   = cmd_data.pressed;
               word_in.last      = 1'b1;
               if (cmd_data.pressed) begin
                  word_in.code = make_first;
               end else if (release_style) begin
                  word_in.code = release_first;
               end else begin
                  // Two-word release: the break prefix goes first, the make code follows.
                  word_in.code = BREAK_PREFIX;
                  word_in.last = 1'b0;
               end
            end
         end
         BK_SECOND: begin
            if (out_free) begin
               valid_in          = 1'b1;
               word_in.code      = make_second;
               word_in.key_index = key_ff;
               word_in.pressed   = 1'b0;
               word_in.last      = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_FIRST;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      key_ff  <= key_in;
   end

endmodule
